>>> hdl/sll_pkg.sv
// ----------------------------------------------------------------------------
// sll_pkg
// Shared types, codes and character helpers for the stack language lexer.
// ----------------------------------------------------------------------------
package sll_pkg;

  typedef enum logic [3:0] {
    M_START    = 4'd0,
    M_COMMENT  = 4'd1,
    M_DEFSTART = 4'd2,
    M_DEFNAME  = 4'd3,
    M_MODULE   = 4'd4,
    M_WORD     = 4'd5,
    M_Q1       = 4'd6,
    M_Q2       = 4'd7,
    M_STR      = 4'd8,
    M_TQ0      = 4'd9,
    M_TQ1      = 4'd10,
    M_TQ2      = 4'd11
  } mode_t;

  localparam logic [1:0] EV_CHAR  = 2'd0;
  localparam logic [1:0] EV_TOKEN = 2'd1;
  localparam logic [1:0] EV_ERROR = 2'd2;

  localparam logic [3:0] K_EOS      = 4'd0;
  localparam logic [3:0] K_COMMENT  = 4'd1;
  localparam logic [3:0] K_STARTDEF = 4'd2;
  localparam logic [3:0] K_ENDDEF   = 4'd3;
  localparam logic [3:0] K_LBRACK   = 4'd4;
  localparam logic [3:0] K_RBRACK   = 4'd5;
  localparam logic [3:0] K_STARTMOD = 4'd6;
  localparam logic [3:0] K_ENDMOD   = 4'd7;
  localparam logic [3:0] K_STRING   = 4'd8;
  localparam logic [3:0] K_WORD     = 4'd9;

  localparam logic [1:0] ERR_QUOTE_DEF  = 2'd0;
  localparam logic [1:0] ERR_END_DEF    = 2'd1;
  localparam logic [1:0] ERR_OPEN_TRIPLE = 2'd2;
  localparam logic [1:0] ERR_OPEN_STR   = 2'd3;

  localparam logic CMD_BYTE = 1'b0;
  localparam logic CMD_EOS  = 1'b1;

  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_CR     = 8'h0d;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_LF     = 8'h0a;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_HASH   = 8'h23;
  localparam logic [7:0] CH_COLON  = 8'h3a;
  localparam logic [7:0] CH_SEMI   = 8'h3b;
  localparam logic [7:0] CH_LBRACK = 8'h5b;
  localparam logic [7:0] CH_RBRACK = 8'h5d;
  localparam logic [7:0] CH_LBRACE = 8'h7b;
  localparam logic [7:0] CH_RBRACE = 8'h7d;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_SQUOTE = 8'h27;

  localparam int MaxRes = 3;
  localparam int FifoDepth = 4;
  localparam int FifoAw = $clog2(FifoDepth);

  typedef struct packed {
    logic [1:0] ev;
    logic [3:0] kind;
    logic [7:0] chr;
    logic [1:0] err;
  } result_t;

  // up to three results caused by one request, slot 0 first
  typedef struct packed {
    logic [1:0]              cnt;
    result_t [MaxRes-1:0]    res;
  } bundle_t;

  function automatic logic is_space(input logic [7:0] c);
    return (c == CH_SPACE) || (c == CH_CR) || (c == CH_TAB) || (c == CH_LF) ||
           (c == CH_LPAREN) || (c == CH_RPAREN);
  endfunction

  function automatic logic opens_string(input logic [7:0] c);
    return (c == CH_DQUOTE) || (c == CH_SQUOTE);
  endfunction

  function automatic result_t mk_res(input logic [1:0] ev, input logic [3:0] kind,
                                     input logic [7:0] chr, input logic [1:0] err);
    result_t r;
    r.ev   = ev;
    r.kind = kind;
    r.chr  = chr;
    r.err  = err;
    return r;
  endfunction

endpackage

>>> hdl/sll_front.sv
// ----------------------------------------------------------------------------
// sll_front
// Lexer mode register and byte classification; emits one result bundle
// per accepted request that causes at least one result.
// ----------------------------------------------------------------------------
module sll_front (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic             cmd,
  input  logic [7:0]       ch,
  input  logic             q_full,
  output logic             q_push,
  output sll_pkg::bundle_t q_data
);
  import sll_pkg::*;

  mode_t      mode;
  mode_t      mode_next;
  logic [7:0] quote;
  logic [7:0] quote_next;

  mode_t      fs_mode;
  logic       fs_put;
  logic       fs_qld;
  result_t    fs_res;

  result_t [MaxRes-1:0] res;
  logic [1:0] n;
  logic       acc;

  assign acc = push && !q_full;

  // what the start mode does with ch
  always_comb begin
    fs_mode = M_START;
    fs_put  = 1'b0;
    fs_qld  = 1'b0;
    fs_res  = '0;
    if (is_space(ch)) begin
      fs_mode = M_START;
    end else if (ch == CH_HASH) begin
      fs_mode = M_COMMENT;
    end else if (ch == CH_COLON) begin
      fs_mode = M_DEFSTART;
    end else if (ch == CH_SEMI) begin
      fs_put = 1'b1;
      fs_res = mk_res(EV_TOKEN, K_ENDDEF, 8'd0, 2'd0);
    end else if (ch == CH_LBRACK) begin
      fs_put = 1'b1;
      fs_res = mk_res(EV_TOKEN, K_LBRACK, 8'd0, 2'd0);
    end else if (ch == CH_RBRACK) begin
      fs_put = 1'b1;
      fs_res = mk_res(EV_TOKEN, K_RBRACK, 8'd0, 2'd0);
    end else if (ch == CH_LBRACE) begin
      fs_mode = M_MODULE;
    end else if (ch == CH_RBRACE) begin
      fs_put = 1'b1;
      fs_res = mk_res(EV_TOKEN, K_ENDMOD, 8'd0, 2'd0);
    end else if (opens_string(ch)) begin
      fs_qld  = 1'b1;
      fs_mode = M_Q1;
    end else begin
      fs_put  = 1'b1;
      fs_res  = mk_res(EV_CHAR, K_WORD, ch, 2'd0);
      fs_mode = M_WORD;
    end
  end

  always_comb begin
    mode_next  = mode;
    quote_next = quote;
    res        = '0;
    n          = 2'd0;
    if (cmd == CMD_EOS) begin
      mode_next = M_START;
      case (mode)
        M_COMMENT: begin
          res[n] = mk_res(EV_TOKEN, K_COMMENT, 8'd0, 2'd0);
          n = n + 2'd1;
        end
        M_DEFNAME: begin
          res[n] = mk_res(EV_TOKEN, K_STARTDEF, 8'd0, 2'd0);
          n = n + 2'd1;
        end
        M_MODULE: begin
          res[n] = mk_res(EV_TOKEN, K_STARTMOD, 8'd0, 2'd0);
          n = n + 2'd1;
        end
        M_WORD: begin
          res[n] = mk_res(EV_TOKEN, K_WORD, 8'd0, 2'd0);
          n = n + 2'd1;
        end
        M_Q2: begin
          res[n] = mk_res(EV_TOKEN, K_STRING, 8'd0, 2'd0);
          n = n + 2'd1;
        end
        M_DEFSTART: begin
          res[n] = mk_res(EV_ERROR, K_EOS, 8'd0, ERR_END_DEF);
          n = n + 2'd1;
        end
        M_Q1, M_STR: begin
          res[n] = mk_res(EV_ERROR, K_EOS, 8'd0, ERR_OPEN_STR);
          n = n + 2'd1;
        end
        M_TQ0, M_TQ1, M_TQ2: begin
          res[n] = mk_res(EV_ERROR, K_EOS, 8'd0, ERR_OPEN_TRIPLE);
          n = n + 2'd1;
        end
        default: begin
        end
      endcase
      if (n == 2'd0 || res[0].ev != EV_ERROR) begin
        res[n] = mk_res(EV_TOKEN, K_EOS, 8'd0, 2'd0);
        n = n + 2'd1;
      end
    end else begin
      case (mode)
        M_COMMENT: begin
          if (ch == CH_LF) begin
            res[n] = mk_res(EV_TOKEN, K_COMMENT, 8'd0, 2'd0);
            n = n + 2'd1;
            mode_next = M_START;
          end else begin
            res[n] = mk_res(EV_CHAR, K_COMMENT, ch, 2'd0);
            n = n + 2'd1;
          end
        end
        M_DEFSTART: begin
          if (is_space(ch)) begin
            mode_next = M_DEFSTART;
          end else if (opens_string(ch)) begin
            res[n] = mk_res(EV_ERROR, K_EOS, 8'd0, ERR_QUOTE_DEF);
            n = n + 2'd1;
            mode_next = M_START;
          end else begin
            res[n] = mk_res(EV_CHAR, K_STARTDEF, ch, 2'd0);
            n = n + 2'd1;
            mode_next = M_DEFNAME;
          end
        end
        M_DEFNAME, M_WORD: begin
          if (is_space(ch)) begin
            res[n] = mk_res(EV_TOKEN, (mode == M_WORD) ? K_WORD : K_STARTDEF,
                            8'd0, 2'd0);
            n = n + 2'd1;
            mode_next = M_START;
          end else begin
            res[n] = mk_res(EV_CHAR, (mode == M_WORD) ? K_WORD : K_STARTDEF,
                            ch, 2'd0);
            n = n + 2'd1;
          end
        end
        M_MODULE: begin
          if (is_space(ch)) begin
            res[n] = mk_res(EV_TOKEN, K_STARTMOD, 8'd0, 2'd0);
            n = n + 2'd1;
            mode_next = M_START;
          end else if (ch == CH_RBRACE) begin
            res[n] = mk_res(EV_TOKEN, K_STARTMOD, 8'd0, 2'd0);
            n = n + 2'd1;
            res[n] = fs_res;
            n = n + 2'd1;
            mode_next = fs_mode;
          end else begin
            res[n] = mk_res(EV_CHAR, K_STARTMOD, ch, 2'd0);
            n = n + 2'd1;
          end
        end
        M_Q1: begin
          if (ch == quote) begin
            mode_next = M_Q2;
          end else begin
            res[n] = mk_res(EV_CHAR, K_STRING, ch, 2'd0);
            n = n + 2'd1;
            mode_next = M_STR;
          end
        end
        M_Q2: begin
          if (ch == quote) begin
            mode_next = M_TQ0;
          end else begin
            res[n] = mk_res(EV_TOKEN, K_STRING, 8'd0, 2'd0);
            n = n + 2'd1;
            if (fs_put) begin
              res[n] = fs_res;
              n = n + 2'd1;
            end
            if (fs_qld) begin
              quote_next = ch;
            end
            mode_next = fs_mode;
          end
        end
        M_STR: begin
          if (ch == quote) begin
            res[n] = mk_res(EV_TOKEN, K_STRING, 8'd0, 2'd0);
            n = n + 2'd1;
            mode_next = M_START;
          end else begin
            res[n] = mk_res(EV_CHAR, K_STRING, ch, 2'd0);
            n = n + 2'd1;
          end
        end
        M_TQ0: begin
          if (ch == quote) begin
            mode_next = M_TQ1;
          end else begin
            res[n] = mk_res(EV_CHAR, K_STRING, ch, 2'd0);
            n = n + 2'd1;
          end
        end
        M_TQ1: begin
          if (ch == quote) begin
            mode_next = M_TQ2;
          end else begin
            res[n] = mk_res(EV_CHAR, K_STRING, quote, 2'd0);
            n = n + 2'd1;
            res[n] = mk_res(EV_CHAR, K_STRING, ch, 2'd0);
            n = n + 2'd1;
            mode_next = M_TQ0;
          end
        end
        M_TQ2: begin
          if (ch == quote) begin
            res[n] = mk_res(EV_TOKEN, K_STRING, 8'd0, 2'd0);
            n = n + 2'd1;
            mode_next = M_START;
          end else begin
            res[n] = mk_res(EV_CHAR, K_STRING, quote, 2'd0);
            n = n + 2'd1;
            res[n] = mk_res(EV_CHAR, K_STRING, quote, 2'd0);
            n = n + 2'd1;
            res[n] = mk_res(EV_CHAR, K_STRING, ch, 2'd0);
            n = n + 2'd1;
            mode_next = M_TQ0;
          end
        end
        default: begin
          if (fs_put) begin
            res[n] = fs_res;
            n = n + 2'd1;
          end
          if (fs_qld) begin
            quote_next = ch;
          end
          mode_next = fs_mode;
        end
      endcase
    end
  end

  assign q_push     = acc && (n != 2'd0);
  assign q_data.cnt = n;
  assign q_data.res = res;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode  <= M_START;
      quote <= 8'd0;
    end else if (acc) begin
      mode  <= mode_next;
      quote <= quote_next;
    end
  end

endmodule

>>> hdl/sll_fifo.sv
// ----------------------------------------------------------------------------
// sll_fifo
// Short queue of result bundles between the lexer front and the emitter.
// ----------------------------------------------------------------------------
module sll_fifo (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr,
  input  sll_pkg::bundle_t wdata,
  input  logic             rd,
  output sll_pkg::bundle_t rdata,
  output logic             full,
  output logic             avail
);
  import sll_pkg::*;

  bundle_t                mem [FifoDepth];
  logic [FifoAw-1:0]      wptr;
  logic [FifoAw-1:0]      rptr;
  logic [FifoAw:0]        count;
  logic                   do_wr;
  logic                   do_rd;

  assign full  = (count == (FifoAw+1)'(FifoDepth));
  assign avail = (count != '0);
  assign do_wr = wr && !full;
  assign do_rd = rd && avail;
  assign rdata = mem[rptr];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (do_wr) begin
        wptr <= wptr + 1'b1;
      end
      if (do_rd) begin
        rptr <= rptr + 1'b1;
      end
      case ({do_wr, do_rd})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

>>> hdl/sll_back.sv
// ----------------------------------------------------------------------------
// sll_back
// Output register: takes one bundle at a time and hands its results out
// one per request, marking the final one.
// ----------------------------------------------------------------------------
module sll_back (
  input  logic             clk,
  input  logic             rst,
  input  logic             q_avail,
  input  sll_pkg::bundle_t q_data,
  output logic             q_pop,
  input  logic             pop,
  output logic             empty,
  output logic [1:0]       event_res,
  output logic [3:0]       token_kind,
  output logic [7:0]       text_char,
  output logic [1:0]       error_code,
  output logic             last
);
  import sll_pkg::*;

  bundle_t    cur;
  logic [1:0] idx;
  logic       vld;
  logic       taken;
  logic       done;
  result_t    r;

  assign r          = cur.res[idx];
  assign empty      = !vld;
  assign event_res  = r.ev;
  assign token_kind = r.kind;
  assign text_char  = r.chr;
  assign error_code = r.err;
  assign last       = (idx == cur.cnt - 2'd1);

  assign taken = pop && vld;
  assign done  = taken && last;
  assign q_pop = q_avail && (!vld || done);

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur <= q_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
      idx <= 2'd0;
    end else if (q_pop) begin
      vld <= 1'b1;
      idx <= 2'd0;
    end else if (done) begin
      vld <= 1'b0;
    end else if (taken) begin
      idx <= idx + 2'd1;
    end
  end

endmodule

>>> hdl/stack_language_lexer.sv
// ----------------------------------------------------------------------------
// stack_language_lexer
// Streaming lexer for a small stack language.
// ----------------------------------------------------------------------------
// Input queue side: push with cmd/ch; a request is taken when push is high
// and full is low. cmd 0 carries one source byte, cmd 1 ends the stream.
// Result queue side: while empty is low the oldest result sits on
// event_res/token_kind/text_char/error_code/last; pop takes it.
// Each request causes zero to three results; last marks the final one.
// A byte that causes no result leaves no trace on the result side.
// Throughput: one request per cycle on input while full is low; one result
// per cycle on output while pop is high. The front stage updates the lexer
// mode and writes any results as a bundle into a 4-entry queue; the emitter
// drains one result per cycle while pop is high, so a steady stream of
// three-result bytes is held to the output rate once the queue fills.
// A result is written into the queue, then loaded into the output register.
// Reset clears the lexer mode, the open quote and the queue; empty goes
// high. When pop stays low results hold, the queue fills and full rises.
// ----------------------------------------------------------------------------
module stack_language_lexer (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  output logic       full,
  input  logic       cmd,
  input  logic [7:0] ch,
  output logic       empty,
  input  logic       pop,
  output logic [1:0] event_res,
  output logic [3:0] token_kind,
  output logic [7:0] text_char,
  output logic [1:0] error_code,
  output logic       last
);
  import sll_pkg::*;

  logic    q_push;
  logic    q_pop;
  logic    q_avail;
  bundle_t q_wdata;
  bundle_t q_rdata;

  sll_front u_front (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .cmd    (cmd),
    .ch     (ch),
    .q_full (full),
    .q_push (q_push),
    .q_data (q_wdata)
  );

  sll_fifo u_fifo (
    .clk   (clk),
    .rst   (rst),
    .wr    (q_push),
    .wdata (q_wdata),
    .rd    (q_pop),
    .rdata (q_rdata),
    .full  (full),
    .avail (q_avail)
  );

  sll_back u_back (
    .clk        (clk),
    .rst        (rst),
    .q_avail    (q_avail),
    .q_data     (q_rdata),
    .q_pop      (q_pop),
    .pop        (pop),
    .empty      (empty),
    .event_res  (event_res),
    .token_kind (token_kind),
    .text_char  (text_char),
    .error_code (error_code),
    .last       (last)
  );

endmodule

>>> hdl/sll_checker.sv
// ----------------------------------------------------------------------------
// sll_checker
// Port-level checks on the lexer result queue.
// ----------------------------------------------------------------------------
module sll_checker (
  input logic       clk,
  input logic       rst,
  input logic       empty,
  input logic       pop,
  input logic [1:0] event_res,
  input logic [3:0] token_kind,
  input logic [7:0] text_char,
  input logic [1:0] error_code,
  input logic       last
);
  import sll_pkg::*;

  a_reset_empty: assert property (@(posedge clk) rst |=> empty)
    else $error("result queue not empty after reset");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(event_res) && $stable(token_kind) &&
                          $stable(text_char) && $stable(error_code) && $stable(last)))
    else $error("stalled result changed");

  a_event_code: assert property (@(posedge clk) disable iff (rst)
    !empty |-> (event_res == EV_CHAR || event_res == EV_TOKEN || event_res == EV_ERROR))
    else $error("bad event code");

  a_error_last: assert property (@(posedge clk) disable iff (rst)
    (!empty && event_res == EV_ERROR) |-> last)
    else $error("error result not final");

  a_eos_last: assert property (@(posedge clk) disable iff (rst)
    (!empty && event_res == EV_TOKEN && token_kind == K_EOS) |-> last)
    else $error("eos token not final");

endmodule

bind stack_language_lexer sll_checker u_sll_checker (.*);
